// File: design/md5_pkg.sv
// Shared types, constants and helper functions for the MD5 digest block.
// Used by md5_block_buf, md5_round and md5_message_digest.
// Depends on nothing.
`timescale 1ns / 1ps

package md5_pkg;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_DONE
    } md5_state_t;

    // What the compression currently running reads from the block buffer.
    typedef enum logic [1:0] {
        BLK_FULL,   // a block of 64 message bytes
        BLK_PAD,    // message tail, the 0x80 marker, zero fill and the length if it fits
        BLK_LEN     // zero words followed by the length
    } md5_kind_t;

    // The four working or chaining words.
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } md5_abcd_t;

    // Control from the sequencer to the block buffer.
    typedef struct packed {
        logic        wr_en;
        logic [5:0]  wr_pos;
        logic [7:0]  wr_byte;
        logic [3:0]  rd_idx;
        md5_kind_t   kind;
        logic [5:0]  fill_pos;
        logic [63:0] bit_len;
    } md5_buf_ctrl_t;

    localparam int unsigned ROUNDS = 64;

    localparam md5_abcd_t INIT_VECTOR = '{
        a: 32'h67452301,
        b: 32'hefcdab89,
        c: 32'h98badcfe,
        d: 32'h10325476
    };

    localparam logic [7:0] PAD_MARKER = 8'h80;

    // Position in the block from which the length no longer fits.
    localparam logic [5:0] LEN_FIT_LIMIT = 6'd56;

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] SHIFT_AMT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22,
        5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23,
        5'd6, 5'd10, 5'd15, 5'd21
    };

    // Message word read in a given round; each phase steps through the
    // sixteen words in its own order.
    function automatic logic [3:0] md5_word_index(input logic [5:0] rnd);
        logic [3:0] j;
        logic [3:0] idx;
        j = rnd[3:0];
        case (rnd[5:4])
            2'd0:    idx = j;
            2'd1:    idx = j * 4'd5 + 4'd1;
            2'd2:    idx = j * 4'd3 + 4'd5;
            default: idx = j * 4'd7;
        endcase
        return idx;
    endfunction

    // Reverse the byte order of a word.
    function automatic logic [31:0] md5_bswap(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage

// File: design/md5_block_buf.sv
// Sixteen-word block buffer with byte writes and a padded read view.
// Depends on md5_pkg for the control struct and the padding constants.
`timescale 1ns / 1ps

module md5_block_buf (
    input  logic                  aclk,
    input  md5_pkg::md5_buf_ctrl_t ctrl,
    output logic [31:0]           rd_word
);
    import md5_pkg::*;

    logic [31:0] mem_reg [16];
    logic [31:0] raw_word;
    logic [31:0] pad_word;
    logic [5:0]  byte_pos [4];

    // Message bytes are stored little-endian within each word.
    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem_reg[ctrl.wr_pos[5:2]][{ctrl.wr_pos[1:0], 3'b000} +: 8] <= ctrl.wr_byte;
        end
    end

    assign raw_word = mem_reg[ctrl.rd_idx];

    // Bytes before the fill position are message data, the byte at it is the
    // marker, and everything after it reads as zero.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            byte_pos[k] = {ctrl.rd_idx, 2'(k)};
            if (byte_pos[k] < ctrl.fill_pos) begin
                pad_word[8*k +: 8] = raw_word[8*k +: 8];
            end else if (byte_pos[k] == ctrl.fill_pos) begin
                pad_word[8*k +: 8] = PAD_MARKER;
            end else begin
                pad_word[8*k +: 8] = 8'h00;
            end
        end
    end

    // Select the view of the word that the current block kind calls for.
    always_comb begin
        case (ctrl.kind)
            BLK_FULL: rd_word = raw_word;
            BLK_PAD: begin
                rd_word = pad_word;
                if (ctrl.fill_pos < LEN_FIT_LIMIT) begin
                    if (ctrl.rd_idx == 4'd14) begin
                        rd_word = ctrl.bit_len[31:0];
                    end else if (ctrl.rd_idx == 4'd15) begin
                        rd_word = ctrl.bit_len[63:32];
                    end
                end
            end
            BLK_LEN: begin
                if (ctrl.rd_idx == 4'd14) begin
                    rd_word = ctrl.bit_len[31:0];
                end else if (ctrl.rd_idx == 4'd15) begin
                    rd_word = ctrl.bit_len[63:32];
                end else begin
                    rd_word = 32'h0;
                end
            end
            default: rd_word = raw_word;
        endcase
    end

endmodule

// File: design/md5_round.sv
// One MD5 round: the shared step unit that the sequencer runs 64 times a block.
// Depends on md5_pkg for the round constants, shift table and word struct.
`timescale 1ns / 1ps

module md5_round (
    input  md5_pkg::md5_abcd_t work_in,
    input  logic [5:0]         rnd,
    input  logic [31:0]        msg_word,
    output md5_pkg::md5_abcd_t work_out
);
    import md5_pkg::*;

    logic [31:0] f_val;
    logic [31:0] sum;
    logic [4:0]  shamt;
    logic [63:0] rot_wide;

    // Boolean function of the current phase.
    always_comb begin
        case (rnd[5:4])
            2'd0:    f_val = (work_in.b & work_in.c) | (~work_in.b & work_in.d);
            2'd1:    f_val = (work_in.d & work_in.b) | (~work_in.d & work_in.c);
            2'd2:    f_val = work_in.b ^ work_in.c ^ work_in.d;
            default: f_val = work_in.c ^ (work_in.b | ~work_in.d);
        endcase
    end

    // Sum, rotate left and rotate the word roles.
    always_comb begin
        sum       = work_in.a + f_val + ROUND_K[rnd] + msg_word;
        shamt     = SHIFT_AMT[{rnd[5:4], rnd[1:0]}];
        rot_wide  = {sum, sum} << shamt;
        work_out.a = work_in.d;
        work_out.d = work_in.c;
        work_out.c = work_in.b;
        work_out.b = work_in.b + rot_wide[63:32];
    end

endmodule

// File: design/md5_message_digest.sv
// Top level of the streaming MD5 digest block: handshakes, sequencer and
// chaining state. Depends on md5_pkg, md5_block_buf and md5_round.
`timescale 1ns / 1ps

// Usage
// The input channel takes one item per handshake: a message byte in s_tdata,
// byte_present in s_tuser and end_of_message in s_tlast. An item that neither
// completes a 64-byte block nor has s_tlast set leaves s_tready high. The item
// that completes a block starts a compression in the shared round unit, one
// round a cycle: 64 rounds (ST_ROUND) and then the add into the chaining words
// (ST_ADD), with s_tready low until the sequencer is back in ST_IDLE.
// An item with s_tlast set runs two compressions when it completes a block or
// leaves no room for the length behind the marker, and one otherwise. It then
// loads the digest into the output register in ST_DONE, waiting there while
// the register still holds a digest not yet taken; s_tready is low throughout.
// The digest appears on m_tdata (128 bits) with m_tvalid and is held until
// m_tready; a further item is accepted meanwhile, and only the loading of the
// next digest waits for the output register to be free.
// After each digest the chaining words return to the initial vector and the
// byte count to zero. Reset (aresetn low, synchronous) does the same and
// empties the output register; the buffer contents need no clearing.

module md5_message_digest (
    input  logic         aclk,
    input  logic         aresetn,
    // Input channel
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] message_byte
    input  logic         s_tuser,   // [0] byte_present
    input  logic         s_tlast,   // end_of_message
    // Result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // [63:0] digest_first_half, [127:64] digest_second_half
);
    import md5_pkg::*;

    md5_state_t    state_reg, state_next;
    md5_kind_t     kind_reg, kind_next;
    logic [5:0]    round_reg, round_next;
    logic          pend_last_reg, pend_last_next;
    logic [63:0]   cnt_reg, cnt_next;
    md5_abcd_t     chain_reg, chain_next;
    md5_abcd_t     work_reg, work_next;
    logic          out_valid_reg, out_valid_next;
    logic [127:0]  out_data_reg, out_data_next;

    logic          accept;
    logic          full_block;
    logic          start_block;
    logic          more_blocks;
    logic          round_en;
    logic          add_en;
    logic          load_out;
    logic          last_round;
    md5_abcd_t     round_out;
    md5_abcd_t     sum_words;
    logic [31:0]   msg_word;
    md5_buf_ctrl_t buf_ctrl;

    // Decisions shared by the sequencer and the datapath.
    assign accept      = s_tvalid && s_tready;
    assign full_block  = s_tuser && (cnt_reg[5:0] == 6'd63);
    assign start_block = accept && (full_block || s_tlast);
    assign last_round  = (round_reg == 6'(ROUNDS - 1));
    assign more_blocks = ((kind_reg == BLK_FULL) && pend_last_reg) ||
                         ((kind_reg == BLK_PAD) && (cnt_reg[5:0] >= LEN_FIT_LIMIT));

    assign sum_words.a = chain_reg.a + work_reg.a;
    assign sum_words.b = chain_reg.b + work_reg.b;
    assign sum_words.c = chain_reg.c + work_reg.c;
    assign sum_words.d = chain_reg.d + work_reg.d;

    // Sequencer: next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start_block) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (last_round) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                if (more_blocks) begin
                    state_next = ST_ROUND;
                end else if (kind_reg == BLK_FULL) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer: outputs.
    always_comb begin
        s_tready = 1'b0;
        round_en = 1'b0;
        add_en   = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_ROUND: round_en = 1'b1;
            ST_ADD:   add_en   = 1'b1;
            ST_DONE:  load_out = !out_valid_reg || m_tready;
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Block buffer control: bytes are written on an accepted item with byte_present, words read by round.
    always_comb begin
        buf_ctrl.wr_en    = accept && s_tuser;
        buf_ctrl.wr_pos   = cnt_reg[5:0];
        buf_ctrl.wr_byte  = s_tdata;
        buf_ctrl.rd_idx   = md5_word_index(round_reg);
        buf_ctrl.kind     = kind_reg;
        buf_ctrl.fill_pos = cnt_reg[5:0];
        buf_ctrl.bit_len  = {cnt_reg[60:0], 3'b000};
    end

    md5_block_buf u_buf (
        .aclk    (aclk),
        .ctrl    (buf_ctrl),
        .rd_word (msg_word)
    );

    md5_round u_round (
        .work_in  (work_reg),
        .rnd      (round_reg),
        .msg_word (msg_word),
        .work_out (round_out)
    );

    // Datapath next values.
    always_comb begin
        kind_next      = kind_reg;
        round_next     = round_reg;
        pend_last_next = pend_last_reg;
        cnt_next       = cnt_reg;
        chain_next     = chain_reg;
        work_next      = work_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        // Take the item in and, if needed, start from the chaining words.
        if (accept) begin
            if (s_tuser) begin
                cnt_next = cnt_reg + 64'd1;
            end
            kind_next      = full_block ? BLK_FULL : BLK_PAD;
            pend_last_next = s_tlast;
            work_next      = chain_reg;
        end

        if (round_en) begin
            work_next  = round_out;
            round_next = round_reg + 6'd1;
        end

        // Fold the block result into the chaining words and pick the next block.
        if (add_en) begin
            chain_next = sum_words;
            work_next  = sum_words;
            if (kind_reg == BLK_FULL) begin
                kind_next = BLK_PAD;
            end else begin
                kind_next = BLK_LEN;
            end
        end

        // Hand the digest over and return to the initial vector.
        if (load_out) begin
            out_valid_next = 1'b1;
            out_data_next  = {md5_bswap(chain_reg.c), md5_bswap(chain_reg.d),
                              md5_bswap(chain_reg.a), md5_bswap(chain_reg.b)};
            chain_next     = INIT_VECTOR;
            cnt_next       = 64'd0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            kind_reg      <= BLK_FULL;
            round_reg     <= 6'd0;
            pend_last_reg <= 1'b0;
            cnt_reg       <= 64'd0;
            chain_reg     <= INIT_VECTOR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            round_reg     <= round_next;
            pend_last_reg <= pend_last_next;
            cnt_reg       <= cnt_next;
            chain_reg     <= chain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        work_reg     <= work_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // The round counter only moves while a compression runs.
    a_round_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_ROUND) |-> (round_reg == 6'd0))
        else $error("round counter not at zero outside a compression");

    // A full message block is compressed only when the count is block aligned.
    a_full_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && kind_reg == BLK_FULL) |-> (cnt_reg[5:0] == 6'd0))
        else $error("full block compressed at an unaligned byte count");

    // A separate length block follows only a tail too long to hold the length.
    a_len_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && kind_reg == BLK_LEN) |->
        (cnt_reg[5:0] >= LEN_FIT_LIMIT))
        else $error("length block run for a short tail");

    // After a digest is handed over the next message starts from scratch.
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $past(load_out)) |->
        (chain_reg == INIT_VECTOR && cnt_reg == 64'd0 && m_tvalid))
        else $error("state not restarted after a digest");

endmodule
